// ----- hw/rtl/qte_pkg.sv -----
// Shared types, constants and helper functions of the quaternion to Euler block.
// No dependencies; every other file of the block imports this package.
package qte_pkg;

    // Fixed field widths and number formats
    localparam int IN_W          = 16;
    localparam int OUT_W         = 14;
    localparam int FRAC_BITS     = 14;
    localparam int CORDIC_STAGES = 16;
    localparam int TAB_LEN       = 24;
    localparam int SH_W          = 5;
    localparam int SC_W          = 16;
    localparam logic [SC_W-1:0] ANGLE_SCALE = SC_W'(10000);

    // Product sums, CORDIC vector and binary angle widths
    localparam int PROD_W = 2 * IN_W;
    localparam int SUM_W  = 44;
    localparam int CW     = SUM_W + 2;
    localparam int ZW     = 34;
    localparam int UW     = ZW;
    localparam int SW     = 32;

    // Square root of a Q60 value: one result bit per step
    localparam int SQ_W     = 61;
    localparam int SQ_STEPS = 31;
    localparam int C_W      = 31;

    // Pipeline depth from input transfer to output register
    localparam int LAT = 3 + SQ_STEPS + 1 + CORDIC_STAGES + 2;

    // Q30 conversion of the pitch sine
    localparam int SH_DN = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
    localparam int SH_UP = (2 * FRAC_BITS < 30) ? 30 - 2 * FRAC_BITS : 0;

    localparam logic signed [SUM_W-1:0] ONE2       = SUM_W'(1) << (2 * FRAC_BITS);
    localparam logic signed [SW-1:0]    Q30_ONE    = SW'(1) << 30;
    localparam logic signed [ZW-1:0]    ANG_HALF_PI = ZW'(1) << 30;
    localparam logic signed [ZW:0]      OFF_PI     = (ZW + 1)'(1) << 31;
    localparam logic signed [ZW:0]      OFF_HALF   = (ZW + 1)'(1) << 30;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } t_vec;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] r;
    } t_sq;

    typedef struct packed {
        t_vec                 roll;
        t_vec                 yaw;
        logic signed [SW-1:0] s;
    } t_rv;

    // atan(2^-i) in binary angle units, pi = 2^31
    function automatic logic [31:0] f_atan(input logic [SH_W-1:0] i);
        logic [31:0] a;
        case (i)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    // Turn a left half plane vector by a quarter turn and flag the zero vector
    function automatic t_vec f_prerot(input logic signed [CW-1:0] y,
                                      input logic signed [CW-1:0] x);
        t_vec v;
        v.zero = (x == '0) && (y == '0);
        v.x    = x;
        v.y    = y;
        v.z    = '0;
        if (x < 0) begin
            if (!y[CW-1]) begin
                v.x = y;
                v.y = -x;
                v.z = ANG_HALF_PI;
            end else begin
                v.x = -y;
                v.y = x;
                v.z = -ANG_HALF_PI;
            end
        end
        return v;
    endfunction

endpackage

// ----- hw/rtl/qte_if.sv -----
// Stream interfaces of the quaternion to Euler block: quaternion in, angles out.
// Depends on qte_pkg for the field widths.
interface qte_quat_if import qte_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] quat_w;
    logic signed [IN_W-1:0] quat_x;
    logic signed [IN_W-1:0] quat_y;
    logic signed [IN_W-1:0] quat_z;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if import qte_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] roll_scaled;
    logic [OUT_W-1:0] pitch_scaled;
    logic [OUT_W-1:0] yaw_scaled;

    modport source (output valid, roll_scaled, pitch_scaled, yaw_scaled, input ready);
    modport sink   (input valid, roll_scaled, pitch_scaled, yaw_scaled, output ready);
endinterface

// ----- hw/rtl/qte_sqrt_cell.sv -----
// One step of the bit-serial integer square root, registered.
// Depends on qte_pkg for t_sq and its width.
module qte_sqrt_cell import qte_pkg::*; (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [SQ_W-1:0] i_bit,
    input  t_sq             i_d,
    output t_sq             o_d
);
    t_sq             r_d;
    t_sq             n_d;
    logic [SQ_W-1:0] w_trial;

    // Try this result bit; keep it when the remainder allows
    always_comb begin
        w_trial = i_d.r + i_bit;
        if (i_d.v >= w_trial) begin
            n_d.v = i_d.v - w_trial;
            n_d.r = (i_d.r >> 1) + i_bit;
        end else begin
            n_d.v = i_d.v;
            n_d.r = i_d.r >> 1;
        end
    end

    // Hand on to the next cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

// ----- hw/rtl/qte_cordic_cell.sv -----
// One vectoring CORDIC micro-rotation, registered.
// Depends on qte_pkg for t_vec and its widths.
module qte_cordic_cell import qte_pkg::*; (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [SH_W-1:0] i_shift,
    input  logic [31:0]     i_atan,
    input  t_vec            i_d,
    output t_vec            o_d
);
    t_vec                 r_d;
    t_vec                 n_d;
    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;
    logic signed [ZW-1:0] w_da;

    // Rotate toward the x axis and accumulate the angle
    always_comb begin
        w_dx   = i_d.x >>> i_shift;
        w_dy   = i_d.y >>> i_shift;
        w_da   = $signed(ZW'(i_atan));
        n_d.zero = i_d.zero;
        if (!i_d.y[CW-1]) begin
            n_d.x = i_d.x + w_dy;
            n_d.y = i_d.y - w_dx;
            n_d.z = i_d.z + w_da;
        end else begin
            n_d.x = i_d.x - w_dy;
            n_d.y = i_d.y + w_dx;
            n_d.z = i_d.z - w_da;
        end
    end

    // Hand on to the next cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule

// ----- hw/rtl/quaternion_to_euler_scaled.sv -----
// Quaternion to scaled roll, pitch and yaw: input stage, square root and CORDIC rows.
// Depends on qte_pkg, qte_if, qte_sqrt_cell and qte_cordic_cell.
//
// Usage:
//   i_quat carries one quaternion (w, x, y, z, signed Q2.14) per transfer.
//   o_euler carries roll, pitch and yaw, each scaled onto 0..10000.
//   Both channels transfer when valid and ready are high at a clock edge.
// Pipeline, from input transfer to output valid: a product stage, a sum stage,
//   the cosine squared stage, 31 square root cells for the pitch
//   cosine, 1 quarter-turn stage, 16 CORDIC cells and 2 scaling stages.
// Throughput: one quaternion per cycle while not stalled; the whole pipeline moves together.
// Stall: while the output register holds an untaken result, the pipeline
//   freezes and i_quat.ready is low; it accepts again in the cycle the
//   result is taken.
// Reset: i_rst_n (synchronous, active low) empties the pipeline; data
//   registers keep stale values that are never shown.
module quaternion_to_euler_scaled import qte_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    qte_quat_if.sink     i_quat,
    qte_euler_if.source  o_euler
);
    logic             w_adv;
    logic [LAT-1:0]   r_vld;

    logic signed [PROD_W-1:0] r_wx, r_yz, r_xx, r_yy, r_wz, r_xy, r_zz, r_wy, r_zx;
    logic signed [SUM_W-1:0]  r_ry, r_rx, r_yy2, r_yx;
    logic signed [SW-1:0]     r_s;
    logic signed [SUM_W-1:0]  n_ry, n_rx, n_yy2, n_yx, n_s2;
    logic signed [SW-1:0]     n_s;

    t_sq                      r_sq0;
    logic signed [SW:0]       w_sqa, w_sqb;
    logic [2*SW-1:0]          w_sqp;
    t_sq                      w_sq [SQ_STEPS+1];
    t_rv                      r_dly [SQ_STEPS+1];

    t_vec                     r_rol0, r_yaw0, r_pit0;
    t_vec                     w_rol [CORDIC_STAGES+1];
    t_vec                     w_yaw [CORDIC_STAGES+1];
    t_vec                     w_pit [CORDIC_STAGES+1];

    logic [UW-1:0]            r_u_rol, r_u_pit, r_u_yaw;
    logic [OUT_W-1:0]         r_o_rol, r_o_pit, r_o_yaw;

    function automatic logic signed [SUM_W-1:0] f_ext(input logic signed [PROD_W-1:0] p);
        return SUM_W'(p);
    endfunction

    // Offset an angle to nonnegative, zero vector reads as angle zero
    function automatic logic [UW-1:0] f_offset(input t_vec v, input logic signed [ZW:0] off);
        logic signed [ZW:0] t;
        t = (v.zero ? (ZW + 1)'(0) : {v.z[ZW-1], v.z}) + off;
        return t[ZW] ? UW'(0) : t[UW-1:0];
    endfunction

    // Scale onto 0..ANGLE_SCALE, truncated and clamped
    function automatic logic [OUT_W-1:0] f_scale(input logic [UW-1:0] u, input logic half);
        logic [UW+SC_W-1:0] p;
        logic [UW+SC_W-1:0] q;
        p = (UW + SC_W)'(u) * (UW + SC_W)'(ANGLE_SCALE);
        q = half ? (p >> 31) : (p >> 32);
        if (q > (UW + SC_W)'(ANGLE_SCALE)) begin
            q = (UW + SC_W)'(ANGLE_SCALE);
        end
        return q[OUT_W-1:0];
    endfunction

    // Advance whenever the output register is free or being taken
    assign w_adv        = !r_vld[LAT-1] || o_euler.ready;
    assign i_quat.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_quat.valid};
        end
    end

    // Stage 1: all products
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_wx <= i_quat.quat_w * i_quat.quat_x;
            r_yz <= i_quat.quat_y * i_quat.quat_z;
            r_xx <= i_quat.quat_x * i_quat.quat_x;
            r_yy <= i_quat.quat_y * i_quat.quat_y;
            r_wz <= i_quat.quat_w * i_quat.quat_z;
            r_xy <= i_quat.quat_x * i_quat.quat_y;
            r_zz <= i_quat.quat_z * i_quat.quat_z;
            r_wy <= i_quat.quat_w * i_quat.quat_y;
            r_zx <= i_quat.quat_z * i_quat.quat_x;
        end
    end

    // Stage 2: product sums and the clamped pitch sine in Q30
    always_comb begin
        n_ry  = (f_ext(r_wx) + f_ext(r_yz)) <<< 1;
        n_rx  = ONE2 - ((f_ext(r_xx) + f_ext(r_yy)) <<< 1);
        n_yy2 = (f_ext(r_wz) + f_ext(r_xy)) <<< 1;
        n_yx  = ONE2 - ((f_ext(r_yy) + f_ext(r_zz)) <<< 1);
        n_s2  = (f_ext(r_wy) - f_ext(r_zx)) <<< 1;
        if (n_s2 > ONE2) begin
            n_s2 = ONE2;
        end
        if (n_s2 < -ONE2) begin
            n_s2 = -ONE2;
        end
        if (2 * FRAC_BITS >= 30) begin
            n_s = SW'(n_s2 >>> SH_DN);
        end else begin
            n_s = SW'(n_s2 <<< SH_UP);
        end
        if (n_s > Q30_ONE) begin
            n_s = Q30_ONE;
        end
        if (n_s < -Q30_ONE) begin
            n_s = -Q30_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ry  <= n_ry;
            r_rx  <= n_rx;
            r_yy2 <= n_yy2;
            r_yx  <= n_yx;
            r_s   <= n_s;
        end
    end

    // Stage 3: cosine squared for the root, quarter turn for roll and yaw
    assign w_sqa = {Q30_ONE[SW-1], Q30_ONE} - {r_s[SW-1], r_s};
    assign w_sqb = {Q30_ONE[SW-1], Q30_ONE} + {r_s[SW-1], r_s};
    assign w_sqp = (2 * SW)'(w_sqa[SW-1:0]) * (2 * SW)'(w_sqb[SW-1:0]);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq0.v         <= w_sqp[SQ_W-1:0];
            r_sq0.r         <= '0;
            r_dly[0].roll   <= f_prerot(CW'(r_ry), CW'(r_rx));
            r_dly[0].yaw    <= f_prerot(CW'(r_yy2), CW'(r_yx));
            r_dly[0].s      <= r_s;
        end
    end

    // Square root row, with roll, yaw and the sine delayed alongside
    assign w_sq[0] = r_sq0;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        qte_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_bit (SQ_W'(1) << (SQ_W - 1 - 2 * k)),
            .i_d   (w_sq[k]),
            .o_d   (w_sq[k+1])
        );

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dly[k+1] <= r_dly[k];
            end
        end
    end

    // Pitch vector from sine and cosine; roll and yaw wait one stage
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rol0 <= r_dly[SQ_STEPS].roll;
            r_yaw0 <= r_dly[SQ_STEPS].yaw;
            r_pit0 <= f_prerot(CW'(r_dly[SQ_STEPS].s),
                               CW'({1'b0, w_sq[SQ_STEPS].r[C_W-1:0]}));
        end
    end

    // Three CORDIC rows side by side
    assign w_rol[0] = r_rol0;
    assign w_yaw[0] = r_yaw0;
    assign w_pit[0] = r_pit0;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        qte_cordic_cell u_rol (
            .i_clk   (i_clk),
            .i_en    (w_adv),
            .i_shift (SH_W'(k)),
            .i_atan  (f_atan(SH_W'(k))),
            .i_d     (w_rol[k]),
            .o_d     (w_rol[k+1])
        );
        qte_cordic_cell u_yaw (
            .i_clk   (i_clk),
            .i_en    (w_adv),
            .i_shift (SH_W'(k)),
            .i_atan  (f_atan(SH_W'(k))),
            .i_d     (w_yaw[k]),
            .o_d     (w_yaw[k+1])
        );
        qte_cordic_cell u_pit (
            .i_clk   (i_clk),
            .i_en    (w_adv),
            .i_shift (SH_W'(k)),
            .i_atan  (f_atan(SH_W'(k))),
            .i_d     (w_pit[k]),
            .o_d     (w_pit[k+1])
        );
    end

    // Offset, then scale into the output register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_u_rol <= f_offset(w_rol[CORDIC_STAGES], OFF_PI);
            r_u_pit <= f_offset(w_pit[CORDIC_STAGES], OFF_HALF);
            r_u_yaw <= f_offset(w_yaw[CORDIC_STAGES], OFF_PI);
            r_o_rol <= f_scale(r_u_rol, 1'b0);
            r_o_pit <= f_scale(r_u_pit, 1'b1);
            r_o_yaw <= f_scale(r_u_yaw, 1'b0);
        end
    end

    assign o_euler.valid        = r_vld[LAT-1];
    assign o_euler.roll_scaled  = r_o_rol;
    assign o_euler.pitch_scaled = r_o_pit;
    assign o_euler.yaw_scaled   = r_o_yaw;

`ifndef ASSERT_OFF
    // A stall freezes the whole pipeline occupancy
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("pipeline moved during a stall");

    // The cosine never exceeds one in Q30
    a_cos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[SQ_STEPS+2] |-> (w_sq[SQ_STEPS].r <= (SQ_W'(1) << 30)))
        else $error("square root result above one");

    // Results stay within the scaled span
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_euler.valid |-> ((SC_W'(o_euler.roll_scaled) <= ANGLE_SCALE)
                       && (SC_W'(o_euler.pitch_scaled) <= ANGLE_SCALE)
                       && (SC_W'(o_euler.yaw_scaled) <= ANGLE_SCALE)))
        else $error("scaled angle out of span");
`endif

endmodule

// ----- dv/qte_tb_if.sv -----
// Testbench-side copy note: the stream interfaces come from the RTL file qte_if.sv.
// Depends on qte_pkg; this file only adds a typed result record for the checker.
`timescale 1ns / 1ps
package qte_tb_pkg;
    import qte_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] roll;
        logic [OUT_W-1:0] pitch;
        logic [OUT_W-1:0] yaw;
    } t_angles;
endpackage

// ----- dv/testbench.sv -----
// Testbench of quaternion_to_euler_scaled: directed and random quaternions,
// angles predicted by a fixed-point CORDIC model. Depends on qte_pkg, qte_if, qte_tb_pkg.
`timescale 1ns / 1ps
module testbench;
    import qte_pkg::*;
    import qte_tb_pkg::*;

    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   n_errors = 0;
    int   idle_cycles = 0;
    bit   hold_off = 1'b0;
    bit   stim_done = 1'b0;
    t_angles angles_q[$];

    qte_quat_if  quat_if();
    qte_euler_if euler_if();

    quaternion_to_euler_scaled dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_quat (quat_if.sink),
        .o_euler(euler_if.source)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        quat_if.valid  = 1'b0;
        quat_if.quat_w = '0;
        quat_if.quat_x = '0;
        quat_if.quat_y = '0;
        quat_if.quat_z = '0;
        euler_if.ready = 1'b0;
    end

    // CORDIC vectoring: angle of (y, x), pi = 2^31
    function automatic longint vec_angle(longint y, longint x);
        longint ang, t, dx, dy;
        longint atab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
            163, 81};
        ang = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; ang = 64'sd1 << 30;
            end else begin
                x = -y; y = t; ang = -(64'sd1 << 30);
            end
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (y >= 0) begin
                x += dy; y -= dx; ang += atab[i];
            end else begin
                x -= dy; y += dx; ang -= atab[i];
            end
        end
        return ang;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // Offset, scale and clamp one angle onto the output field
    function automatic logic [OUT_W-1:0] scale_angle(longint a, longint off, int sh);
        longint u;
        longint unsigned r;
        u = a + off;
        if (u < 0) u = 0;
        r = (longint'(u) * longint'(ANGLE_SCALE)) >> sh;
        if (r > longint'(ANGLE_SCALE)) r = longint'(ANGLE_SCALE);
        return r[OUT_W-1:0];
    endfunction

    function automatic t_angles euler_of(logic signed [15:0] qw, logic signed [15:0] qx,
                                         logic signed [15:0] qy, logic signed [15:0] qz);
        longint w, x, y, z, one2, s2, s, c;
        t_angles e;
        w = qw; x = qx; y = qy; z = qz;
        one2 = 64'sd1 << (2 * FRAC_BITS);
        e.roll = scale_angle(vec_angle(2 * (w * x + y * z), one2 - 2 * (x * x + y * y)),
                             64'sd1 << 31, 32);
        e.yaw  = scale_angle(vec_angle(2 * (w * z + x * y), one2 - 2 * (y * y + z * z)),
                             64'sd1 << 31, 32);
        s2 = 2 * (w * y - z * x);
        if (s2 > one2) s2 = one2;
        if (s2 < -one2) s2 = -one2;
        if (2 * FRAC_BITS >= 30) s = s2 >>> (2 * FRAC_BITS - 30);
        else s = s2 <<< (30 - 2 * FRAC_BITS);
        c = int_sqrt(longint'((64'sd1 << 30) - s) * longint'((64'sd1 << 30) + s));
        e.pitch = scale_angle(vec_angle(s, c), 64'sd1 << 30, 31);
        return e;
    endfunction

    // Offer one quaternion, after a random gap unless no_gap is set; hold until transferred
    task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                             bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            quat_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        quat_if.valid  <= 1'b1;
        quat_if.quat_w <= w;
        quat_if.quat_x <= x;
        quat_if.quat_y <= y;
        quat_if.quat_z <= z;
        angles_q = {angles_q, euler_of(w, x, y, z)};
        do @(posedge i_clk); while (!quat_if.ready);
    endtask

    function automatic logic [15:0] rand_comp();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    task automatic test_extremes();
        logic [15:0] v[6] = '{16'h4000, 16'hC000, 16'h0000, 16'h7FFF, 16'h8000, 16'h2D41};
        for (int i = 0; i < 6; i++)
            send_quat(v[i], v[(i + 1) % 6], v[(i + 2) % 6], v[(i + 3) % 6]);
        // zero vector, identity, half turns about each axis
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000);
        send_quat(16'h0000, 16'h4000, 16'h0000, 16'h0000);
        send_quat(16'h0000, 16'h0000, 16'h4000, 16'h0000);
        send_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000);
        // gimbal lock, pitch clamped at both ends
        send_quat(16'h2D41, 16'h0000, 16'h2D41, 16'h0000);
        send_quat(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000);
        send_quat(16'h4000, 16'h4000, 16'h4000, 16'hC000);
        send_quat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
    endtask

    task automatic test_unit_random(int n);
        real a, b, c, d, m;
        for (int i = 0; i < n; i++) begin
            a = $signed($urandom_range(0, 2000)) - 1000.0;
            b = $signed($urandom_range(0, 2000)) - 1000.0;
            c = $signed($urandom_range(0, 2000)) - 1000.0;
            d = $signed($urandom_range(0, 2000)) - 1000.0;
            m = $sqrt(a * a + b * b + c * c + d * d);
            if (m < 1.0) m = 1.0;
            send_quat(16'($rtoi(a * 16384.0 / m)), 16'($rtoi(b * 16384.0 / m)),
                      16'($rtoi(c * 16384.0 / m)), 16'($rtoi(d * 16384.0 / m)));
        end
    endtask

    task automatic test_raw_random(int n);
        for (int i = 0; i < n; i++)
            if ($urandom_range(0, 1))
                send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            else send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    endtask

    // Fill the pipeline while the receiver holds off
    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 80; i++)
            send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp(), 1);
    endtask

    // Receiver: random stalls, a long hold-off on request
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            if (hold_off) begin
                euler_if.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                euler_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            euler_if.ready <= 1'b1;
            do @(posedge i_clk); while (!euler_if.valid);
        end
    end

    // Compare each transferred result with the oldest prediction
    always @(posedge i_clk) begin
        t_angles got, exp_a;
        if (i_rst_n && euler_if.valid && euler_if.ready) begin
            got = '{euler_if.roll_scaled, euler_if.pitch_scaled, euler_if.yaw_scaled};
            if (angles_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result %p", got);
            end else begin
                exp_a = angles_q.pop_front();
                if (got !== exp_a) begin
                    n_errors++;
                    if (n_errors <= 10) $display("mismatch: expected %p got %p", exp_a, got);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((quat_if.valid && quat_if.ready) || (euler_if.valid && euler_if.ready))
            idle_cycles <= 0;
        else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("[quaternion_to_euler_scaled] ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_backpressure();
        test_unit_random(800);
        test_raw_random(420);
        quat_if.valid <= 1'b0;
        wait (angles_q.size() == 0);
        repeat (LAT + 20) @(posedge i_clk);
        if (n_errors == 0 && angles_q.size() == 0)
            $display("[quaternion_to_euler_scaled] OK");
        else
            $display("[quaternion_to_euler_scaled] ERROR");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/qte_pkg.sv
hw/rtl/qte_if.sv
hw/rtl/qte_sqrt_cell.sv
hw/rtl/qte_cordic_cell.sv
hw/rtl/quaternion_to_euler_scaled.sv
dv/qte_tb_if.sv
dv/testbench.sv
